### design/ste_pkg.sv
package ste_pkg;

   // item operation codes
   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   // search algorithm codes
   localparam logic [1:0] MODE_LINEAR = 2'd0;
   localparam logic [1:0] MODE_BINARY = 2'd1;
   localparam logic [1:0] MODE_INTERP = 2'd2;
   localparam logic [1:0] MODE_EXPO   = 2'd3;

   // register indexes
   localparam logic REG_ENTRY_COUNT = 1'b0;
   localparam logic REG_SEARCH_MODE = 1'b1;

   // field widths
   localparam int VALUE_W = 32;
   localparam int ADDR_W  = 10;
   localparam int COUNT_W = 11;
   localparam int MODE_W  = 2;
   localparam int CSR_AW  = 3;
   localparam int CSR_DW  = 32;

   localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1;
   localparam logic [MODE_W-1:0]  MODE_RESET  = MODE_BINARY;

endpackage

### design/ste_if.sv
interface ste_req_if;
   logic                                    valid;
   logic                                    ready;
   logic                                    op;
   logic        [ste_pkg::ADDR_W-1:0]       entry_addr;
   logic signed [ste_pkg::VALUE_W-1:0]      entry_value;
   logic signed [ste_pkg::VALUE_W-1:0]      search_key;

   modport source (output valid, op, entry_addr, entry_value, search_key, input ready);
   modport sink   (input valid, op, entry_addr, entry_value, search_key, output ready);
endinterface

interface ste_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         found;
   logic [ste_pkg::ADDR_W-1:0]   match_index;

   modport source (output valid, found, match_index, input ready);
   modport sink   (input valid, found, match_index, output ready);
endinterface

### design/sorted_table_search_engine_unit.sv
// write items store an entry and give no result; a search reads the table
// through its one registered read port, and interpolation divides with a
// bit-serial restoring divider that makes NW quotient bits, NW the product width
// throughput: one search in flight; the next item is taken while a result waits
// reset: synchronous; clears control, presets the CSRs; table contents undefined
module sorted_table_search_engine_unit #(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   ste_req_if.sink                       req,
   ste_rsp_if.source                     rsp,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [ste_pkg::CSR_AW-1:0]    paddr,
   input  logic [ste_pkg::CSR_DW-1:0]    pwdata,
   output logic [ste_pkg::CSR_DW-1:0]    prdata,
   output logic                          pready
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int IW = AW + 2;                  // signed, holds -1 up to 2**(AW+1)-1
   localparam int NW = ste_pkg::VALUE_W + 1 + IW; // interpolation product width
   localparam int CW = $clog2(NW);

   // sequencer state codes
   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_LIN  = 4'd1;
   localparam logic [3:0] S_BIN  = 4'd2;
   localparam logic [3:0] S_ILO  = 4'd3;
   localparam logic [3:0] S_IHI  = 4'd4;
   localparam logic [3:0] S_IMUL = 4'd5;
   localparam logic [3:0] S_IDIV = 4'd6;
   localparam logic [3:0] S_ICHK = 4'd7;
   localparam logic [3:0] S_IPOS = 4'd8;
   localparam logic [3:0] S_EXP0 = 4'd9;
   localparam logic [3:0] S_EXPG = 4'd10;
   localparam logic [3:0] S_DONE = 4'd11;

   // table memory, one write and one registered read port
   logic signed [ste_pkg::VALUE_W-1:0] mem [TABLE_DEPTH];
   logic signed [ste_pkg::VALUE_W-1:0] rd_data_ff;
   logic        [AW-1:0]               rd_addr;
   logic                               mem_we;
   logic        [31:0]                 wr_addr_wide;

   // configuration registers
   logic [ste_pkg::COUNT_W-1:0] entry_count_ff;
   logic [ste_pkg::MODE_W-1:0]  search_mode_ff;
   logic                        csr_write;

   // sequencer registers
   logic [3:0]                         state_ff, state_in;
   logic                               phase_ff, phase_in;
   logic signed [ste_pkg::VALUE_W-1:0] key_ff, key_in;
   logic signed [IW-1:0]               n_ff, n_in;
   logic signed [IW-1:0]               lo_ff, lo_in;
   logic signed [IW-1:0]               hi_ff, hi_in;
   logic signed [IW-1:0]               idx_ff, idx_in;
   logic signed [ste_pkg::VALUE_W-1:0] tlo_ff, tlo_in;
   logic signed [ste_pkg::VALUE_W-1:0] thi_ff, thi_in;
   logic [ste_pkg::VALUE_W:0]          den_ff, den_in;
   logic [ste_pkg::VALUE_W:0]          rem_ff, rem_in;
   logic [NW-1:0]                      quo_ff, quo_in;
   logic [CW-1:0]                      cnt_ff, cnt_in;
   logic                               res_found_ff, res_found_in;
   logic [ste_pkg::ADDR_W-1:0]         res_idx_ff, res_idx_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic                               rsp_found_ff, rsp_found_in;
   logic [ste_pkg::ADDR_W-1:0]         rsp_index_ff, rsp_index_in;

   // combinational helpers
   logic                               req_xfer;
   logic signed [IW:0]                 mid_sum;
   logic signed [IW-1:0]               mid;
   logic signed [IW-1:0]               n_start;
   logic signed [ste_pkg::VALUE_W:0]   diff;
   logic [IW-1:0]                      span;
   logic [ste_pkg::VALUE_W+1:0]        trial;
   logic [ste_pkg::VALUE_W+1:0]        trial_sub;
   logic [NW-1:0]                      quo_next;
   logic signed [IW:0]                 pos_wide;
   logic                               quo_high;

   // ---------------------------------------------------------------- csr port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= ste_pkg::COUNT_RESET;
         search_mode_ff <= ste_pkg::MODE_RESET;
      end else if (csr_write) begin
         unique case (paddr[2])
            ste_pkg::REG_ENTRY_COUNT: entry_count_ff <= pwdata[ste_pkg::COUNT_W-1:0];
            ste_pkg::REG_SEARCH_MODE: search_mode_ff <= pwdata[ste_pkg::MODE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         ste_pkg::REG_ENTRY_COUNT: prdata = ste_pkg::CSR_DW'(entry_count_ff);
         ste_pkg::REG_SEARCH_MODE: prdata = ste_pkg::CSR_DW'(search_mode_ff);
         default:                  prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- table
   assign req.ready    = (state_ff == S_IDLE);
   assign req_xfer     = req.valid && req.ready;
   assign wr_addr_wide = 32'(req.entry_addr);
   // writes beyond the table depth are dropped
   assign mem_we       = req_xfer && (req.op == ste_pkg::OP_WRITE)
                         && (wr_addr_wide < 32'(TABLE_DEPTH));

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr_wide[AW-1:0]] <= req.entry_value;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // probe address follows the state; its data is used next cycle, in phase 1
   assign mid_sum = (IW+1)'(lo_ff) + (IW+1)'(hi_ff);
   assign mid     = IW'(mid_sum >>> 1);

   always_comb begin
      case (state_ff)
         S_BIN:               rd_addr = mid[AW-1:0];
         S_ILO:               rd_addr = lo_ff[AW-1:0];
         S_IHI:               rd_addr = hi_ff[AW-1:0];
         S_LIN, S_IPOS,
         S_EXPG:              rd_addr = idx_ff[AW-1:0];
         default:             rd_addr = '0;
      endcase
   end

   // count saturates at the table depth
   assign n_start = (32'(entry_count_ff) > 32'(TABLE_DEPTH)) ? IW'(TABLE_DEPTH)
                                                            : IW'(entry_count_ff);

   // interpolation operands: key minus low entry, and the index span
   assign diff = (ste_pkg::VALUE_W+1)'(key_ff) - (ste_pkg::VALUE_W+1)'(tlo_ff);
   assign span = IW'(hi_ff - lo_ff);

   // one restoring step of the bit-serial divider
   assign trial     = {rem_ff, quo_ff[NW-1]};
   assign trial_sub = trial - (ste_pkg::VALUE_W+2)'(den_ff);
   assign quo_next  = {quo_ff[NW-2:0], (trial >= (ste_pkg::VALUE_W+2)'(den_ff))};

   // probe position from the quotient
   assign quo_high = |(quo_ff >> (IW - 1));
   assign pos_wide = (IW+1)'(lo_ff) + (IW+1)'($signed({1'b0, quo_ff[IW-2:0]}));

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      key_in       = key_ff;
      n_in         = n_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      idx_in       = idx_ff;
      tlo_in       = tlo_ff;
      thi_in       = thi_ff;
      den_in       = den_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      res_found_in = res_found_ff;
      res_idx_in   = res_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_found_in = rsp_found_ff;
      rsp_index_in = rsp_index_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer && (req.op == ste_pkg::OP_SEARCH)) begin
               key_in       = req.search_key;
               n_in         = n_start;
               lo_in        = '0;
               hi_in        = n_start - IW'(1);
               idx_in       = '0;
               phase_in     = 1'b0;
               res_found_in = 1'b0;
               res_idx_in   = '0;
               if (n_start == '0) begin
                  state_in = S_DONE;               // empty table
               end else begin
                  unique case (search_mode_ff)
                     ste_pkg::MODE_LINEAR: state_in = S_LIN;
                     ste_pkg::MODE_BINARY: state_in = S_BIN;
                     ste_pkg::MODE_INTERP: state_in = S_ILO;
                     ste_pkg::MODE_EXPO:   state_in = S_EXP0;
                     default:              state_in = S_BIN;
                  endcase
               end
            end
         end
         S_LIN: begin
            if (!phase_ff) begin
               if (idx_ff >= n_ff) state_in = S_DONE;
               else                phase_in = 1'b1;
            end else begin
               phase_in = 1'b0;
               if (rd_data_ff == key_ff) begin
                  res_found_in = 1'b1;
                  res_idx_in   = ste_pkg::ADDR_W'(idx_ff);
                  state_in     = S_DONE;
               end else begin
                  idx_in = idx_ff + IW'(1);
               end
            end
         end
         S_BIN: begin
            if (!phase_ff) begin
               if (lo_ff > hi_ff) state_in = S_DONE;
               else               phase_in = 1'b1;
            end else begin
               phase_in = 1'b0;
               if (rd_data_ff == key_ff) begin
                  res_found_in = 1'b1;
                  res_idx_in   = ste_pkg::ADDR_W'(mid);
                  state_in     = S_DONE;
               end else if (rd_data_ff < key_ff) begin
                  lo_in = mid + IW'(1);
               end else begin
                  hi_in = mid - IW'(1);
               end
            end
         end
         S_ILO: begin
            if (!phase_ff) begin
               if (lo_ff > hi_ff) state_in = S_DONE;
               else               phase_in = 1'b1;
            end else begin
               phase_in = 1'b0;
               tlo_in   = rd_data_ff;
               state_in = S_IHI;
            end
         end
         S_IHI: begin
            if (!phase_ff) begin
               phase_in = 1'b1;
            end else begin
               phase_in = 1'b0;
               thi_in   = rd_data_ff;
               if ((key_ff < tlo_ff) || (key_ff > rd_data_ff)) begin
                  state_in = S_DONE;
               end else if (rd_data_ff == tlo_ff) begin
                  // flat bracket: only the low end can match
                  res_found_in = (tlo_ff == key_ff);
                  res_idx_in   = (tlo_ff == key_ff) ? ste_pkg::ADDR_W'(lo_ff) : '0;
                  state_in     = S_DONE;
               end else begin
                  state_in = S_IMUL;
               end
            end
         end
         S_IMUL: begin
            quo_in   = NW'(diff[ste_pkg::VALUE_W:0]) * NW'(span);
            den_in   = (ste_pkg::VALUE_W+1)'((ste_pkg::VALUE_W+1)'(thi_ff)
                                             - (ste_pkg::VALUE_W+1)'(tlo_ff));
            rem_in   = '0;
            cnt_in   = '0;
            state_in = S_IDIV;
         end
         S_IDIV: begin
            quo_in = quo_next;
            rem_in = quo_next[0] ? trial_sub[ste_pkg::VALUE_W:0] : trial[ste_pkg::VALUE_W:0];
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(NW - 1)) state_in = S_ICHK;
         end
         S_ICHK: begin
            if (quo_high || (pos_wide > (IW+1)'(hi_ff)) || (den_ff == '0)) begin
               state_in = S_DONE;
            end else begin
               idx_in   = IW'(pos_wide);
               phase_in = 1'b0;
               state_in = S_IPOS;
            end
         end
         S_IPOS: begin
            if (!phase_ff) begin
               phase_in = 1'b1;
            end else begin
               phase_in = 1'b0;
               state_in = S_ILO;
               if (rd_data_ff == key_ff) begin
                  res_found_in = 1'b1;
                  res_idx_in   = ste_pkg::ADDR_W'(idx_ff);
                  state_in     = S_DONE;
               end else if (rd_data_ff < key_ff) begin
                  lo_in = idx_ff + IW'(1);
               end else begin
                  hi_in = idx_ff - IW'(1);
               end
            end
         end
         S_EXP0: begin
            if (!phase_ff) begin
               phase_in = 1'b1;
            end else begin
               phase_in = 1'b0;
               if (rd_data_ff == key_ff) begin
                  res_found_in = 1'b1;
                  res_idx_in   = '0;
                  state_in     = S_DONE;
               end else begin
                  idx_in   = IW'(1);
                  state_in = S_EXPG;
               end
            end
         end
         S_EXPG: begin
            // galloping probe, then binary search over the bracket
            if (!phase_ff) begin
               if (idx_ff < n_ff) begin
                  phase_in = 1'b1;
               end else begin
                  lo_in    = idx_ff >>> 1;
                  hi_in    = n_ff - IW'(1);
                  state_in = S_BIN;
               end
            end else begin
               phase_in = 1'b0;
               if (rd_data_ff <= key_ff) begin
                  idx_in = idx_ff <<< 1;
               end else begin
                  lo_in    = idx_ff >>> 1;
                  hi_in    = idx_ff;
                  state_in = S_BIN;
               end
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = res_found_ff;
               rsp_index_in = res_idx_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      key_ff       <= key_in;
      n_ff         <= n_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      idx_ff       <= idx_in;
      tlo_ff       <= tlo_in;
      thi_ff       <= thi_in;
      den_ff       <= den_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      cnt_ff       <= cnt_in;
      res_found_ff <= res_found_in;
      res_idx_ff   <= res_idx_in;
      rsp_found_ff <= rsp_found_in;
      rsp_index_ff <= rsp_index_in;
   end

   // result register towards the consumer
   assign rsp.valid       = rsp_valid_ff;
   assign rsp.found       = rsp_found_ff;
   assign rsp.match_index = rsp_index_ff;

   // ---------------------------------------------------------------- checks
   // table writes happen only between searches
   a_write_idle: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == S_IDLE))
      else $error("table written during a search");

   // a binary probe is only ever issued on a non-empty bracket
   a_bin_bracket: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_BIN && phase_ff) |-> (lo_ff <= hi_ff))
      else $error("binary probe outside its bracket");

   // a new result only appears from the completion state
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_DONE))
      else $error("result raised outside completion");

   // the interpolated probe never lies past the bracket span
   a_quo_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ICHK) |-> (quo_ff <= NW'(span)))
      else $error("interpolation quotient out of range");

endmodule
